// File: rtl/fla_pkg.sv
// Shared types and fixed-point constants for the fast log2 approximation pipeline.
package fla_pkg;

	localparam int Q_FRAC    = 30;
	localparam int OUT_W     = 26;
	localparam int ACC_W     = 41;
	localparam int REM_W     = 31;
	localparam int QUO_W     = 32;
	localparam int DIV_STEPS = QUO_W;

	localparam logic [63:0] K_A64 =
		((64'd12422551499 << Q_FRAC) + 64'd50000000) / 64'd100000000;
	localparam logic [63:0] K_B64 =
		((64'd1498030302 << Q_FRAC) + 64'd500000000) / 64'd1000000000;
	localparam logic [63:0] K_C64 =
		((64'd172587999 << Q_FRAC) + 64'd50000000) / 64'd100000000;
	localparam logic [63:0] K_D64 =
		((64'd3520887068 << Q_FRAC) + 64'd5000000000) / 64'd10000000000;

	localparam logic [37:0] K_A = K_A64[37:0];
	localparam logic [30:0] K_B = K_B64[30:0];
	localparam logic [30:0] K_C = K_C64[30:0];
	localparam logic [28:0] K_D = K_D64[28:0];

	typedef logic signed [ACC_W-1:0] acc_t;

	localparam acc_t OUT_MAX = 41'sd33554431;
	localparam acc_t OUT_MIN = -41'sd33554432;

	typedef struct packed {
		logic [REM_W-1:0] rem;
		logic [QUO_W-1:0] low;
		logic [REM_W-1:0] den;
		logic [QUO_W-1:0] quo;
		acc_t             acc;
	} div_t;

endpackage

// File: rtl/fla_front.sv
// Front stages: mantissa product, divisor, dividend and coarse estimate sum.
module fla_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              in_valid,
	input  logic [31:0]       float_bits,
	output logic              v_s2,
	output fla_pkg::div_t     st_s2
);
	import fla_pkg::*;

	logic              v_s1;
	logic [54:0]       prod_s1;
	logic [REM_W-1:0]  den_s1;
	logic [31:0]       bits_s1;
	logic [23:0]       m24;
	logic [54:0]       bm_w;
	logic [30:0]       bm;
	logic [60:0]       num;
	logic [ACC_W-1:0]  diff;
	div_t              nxt;

	assign m24 = {1'b1, float_bits[22:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			prod_s1 <= {24'b0, K_B} * {31'b0, m24};
			den_s1  <= {2'b0, K_D} + {1'b0, m24, 6'b0};
			bits_s1 <= float_bits;
		end
	end

	assign bm_w = prod_s1 + (55'd1 << 23);
	assign bm   = bm_w[54:24];
	assign num  = {K_C, 30'b0} + {31'b0, den_s1[REM_W-1:1]};
	assign diff = {2'b0, bits_s1, 7'b0} - {3'b0, K_A} - {10'b0, bm};

	always_comb begin
		nxt.rem = {2'b0, num[60:32]};
		nxt.low = num[31:0];
		nxt.den = den_s1;
		nxt.quo = '0;
		nxt.acc = signed'(diff);
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			st_s2 <= nxt;
		end
	end

endmodule

// File: rtl/fla_div.sv
// Pipelined restoring divider, one quotient bit per stage, carrying the partial sum.
module fla_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              advance,
	input  logic              in_v,
	input  fla_pkg::div_t     in_st,
	output logic              out_v,
	output fla_pkg::div_t     out_st
);
	import fla_pkg::*;

	div_t pipe   [DIV_STEPS+1];
	logic pipe_v [DIV_STEPS+1];

	assign pipe[0]   = in_st;
	assign pipe_v[0] = in_v;

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		div_t              st_s;
		logic              v_s;
		div_t              nxt;
		logic [QUO_W-1:0]  t;
		logic [QUO_W:0]    d;
		logic              ge;

		always_comb begin
			t       = {pipe[k].rem, pipe[k].low[QUO_W-1]};
			d       = {1'b0, t} - {2'b0, pipe[k].den};
			ge      = !d[QUO_W];
			nxt     = pipe[k];
			nxt.rem = ge ? d[REM_W-1:0] : t[REM_W-1:0];
			nxt.low = {pipe[k].low[QUO_W-2:0], 1'b0};
			nxt.quo = {pipe[k].quo[QUO_W-2:0], ge};
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s <= 1'b0;
			end else if (advance) begin
				v_s <= pipe_v[k];
			end
		end

		always_ff @(posedge clk) begin
			if (advance) begin
				st_s <= nxt;
			end
		end

		assign pipe[k+1]   = st_s;
		assign pipe_v[k+1] = v_s;
	end

	assign out_st = pipe[DIV_STEPS];
	assign out_v  = pipe_v[DIV_STEPS];

endmodule

// File: rtl/fla_out.sv
// Final rounding and saturation, output register and skid buffer.
module fla_out #(
	parameter int FRAC_BITS = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           up_v,
	input  fla_pkg::div_t                  up_st,
	output logic                           advance,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic signed [fla_pkg::OUT_W-1:0] log2_value
);
	import fla_pkg::*;

	localparam int   SH  = Q_FRAC - FRAC_BITS;
	localparam acc_t RND = acc_t'(1) <<< (SH - 1);

	acc_t                     sum;
	acc_t                     rnd;
	logic signed [OUT_W-1:0]  up_val;
	logic signed [OUT_W-1:0]  res_q;
	logic signed [OUT_W-1:0]  skid_q;
	logic                     res_v_q;
	logic                     skid_v_q;
	logic                     take;

	assign sum = up_st.acc - signed'({9'b0, up_st.quo});
	assign rnd = (sum + RND) >>> SH;

	always_comb begin
		if (rnd > OUT_MAX) begin
			up_val = OUT_MAX[OUT_W-1:0];
		end else if (rnd < OUT_MIN) begin
			up_val = OUT_MIN[OUT_W-1:0];
		end else begin
			up_val = rnd[OUT_W-1:0];
		end
	end

	assign advance    = !skid_v_q;
	assign take       = !res_v_q || out_ready;
	assign out_valid  = res_v_q;
	assign log2_value = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (take) begin
			res_v_q  <= skid_v_q || up_v;
			skid_v_q <= 1'b0;
		end else if (up_v && !skid_v_q) begin
			skid_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			res_q <= skid_v_q ? skid_q : up_val;
		end else if (up_v && !skid_v_q) begin
			skid_q <= up_val;
		end
	end

	a_skid_needs_res: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q |-> res_v_q)
		else $error("skid holds a result while output register is empty");

	a_skid_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_v_q) |-> $past(res_v_q && !out_ready))
		else $error("skid filled without an output stall");

	a_skid_drain: assert property (@(posedge clk) disable iff (!arst_n)
		skid_v_q && out_ready |=> res_v_q && res_q == $past(skid_q))
		else $error("skid contents not moved to output register");

endmodule

// File: rtl/fast_log2_approx_core.sv
// Top level of the pipelined fixed-point fast log2 approximation.
//
// Input channel: in_valid / in_ready with float_bits, the raw single-precision
// pattern. Output channel: out_valid / out_ready with log2_value, signed
// two's complement with FRAC_BITS fraction bits, rounded to nearest and
// saturated to 26 bits. No special handling of zero, negative, infinite or NaN.
// A result passes from its input transfer to out_valid through the pipeline:
// two front stages (product, dividend and sum), 32 divider stages at one
// quotient bit each, then the output register.
// Throughput: one transfer per cycle while the skid register is empty, set by the
// divider retiring one quotient bit per stage with every stage registered.
// A skid register behind the output register takes one more result when the
// receiver stalls; in_ready drops only once the skid is full, and the whole
// pipeline then holds. Nothing is lost or repeated across a stall.
// Reset clears all valid bits; no clearing pass is needed, and the block
// accepts input in the first cycle after reset.
module fast_log2_approx_core #(
	parameter int FRAC_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [31:0]                     float_bits,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic signed [fla_pkg::OUT_W-1:0] log2_value
);
	import fla_pkg::*;

	logic advance;
	logic v_s2;
	div_t st_s2;
	logic div_v;
	div_t div_st;

	assign in_ready = advance;

	fla_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.advance    (advance),
		.in_valid   (in_valid),
		.float_bits (float_bits),
		.v_s2       (v_s2),
		.st_s2      (st_s2)
	);

	fla_div u_div (
		.clk     (clk),
		.arst_n  (arst_n),
		.advance (advance),
		.in_v    (v_s2),
		.in_st   (st_s2),
		.out_v   (div_v),
		.out_st  (div_st)
	);

	fla_out #(
		.FRAC_BITS (FRAC_BITS)
	) u_out (
		.clk        (clk),
		.arst_n     (arst_n),
		.up_v       (div_v),
		.up_st      (div_st),
		.advance    (advance),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.log2_value (log2_value)
	);

endmodule

// File: sim/testbench.sv
// Self-checking testbench for fast_log2_approx_core: directed and random float patterns.
`timescale 1ns / 1ps

module testbench;

	localparam int FRAC = 16;
	localparam int RND_SHIFT = 30 - FRAC;
	localparam int HOLD_CYCLES = 400;
	localparam int STALL_ITEMS = 120;
	localparam int RANDOM_ITEMS = 720;
	localparam int TAIL_CYCLES = 40;

	localparam logic [63:0] LOG_OFFSET_Q30 =
		((64'd12422551499 << 30) + 64'd50000000) / 64'd100000000;
	localparam logic [63:0] SLOPE_Q30 =
		((64'd1498030302 << 30) + 64'd500000000) / 64'd1000000000;
	localparam logic [63:0] NUMER_Q30 =
		((64'd172587999 << 30) + 64'd50000000) / 64'd100000000;
	localparam logic [63:0] POLE_Q30 =
		((64'd3520887068 << 30) + 64'd5000000000) / 64'd10000000000;

	localparam longint LOG2_MAX = 64'sd33554431;
	localparam longint LOG2_MIN = -64'sd33554432;

	localparam int N_DIRECTED = 20;
	localparam logic [31:0] DIRECTED_FLOATS [0:N_DIRECTED-1] = '{
		32'h0000_0000, 32'hFFFF_FFFF, 32'h3F80_0000, 32'h3F00_0000,
		32'h7F80_0000, 32'h7FC0_0000, 32'h8000_0000, 32'hBF80_0000,
		32'h0000_0001, 32'h007F_FFFF, 32'h0080_0000, 32'h7F7F_FFFF,
		32'hFF80_0000, 32'h4000_0000, 32'h4120_0000, 32'h3F7F_FFFF,
		32'h3FFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 32'h4B00_0000
	};

	typedef enum logic [1:0] {
		RX_OPEN,
		RX_COIN,
		RX_SPARSE,
		RX_PERIODIC
	} rx_mode_t;

	logic                                 clk;
	logic                                 arst_n;
	logic                                 in_valid;
	logic                                 in_ready;
	logic [31:0]                          float_bits;
	logic                                 out_valid;
	logic                                 out_ready;
	logic signed [fla_pkg::OUT_W-1:0]     log2_value;

	logic signed [fla_pkg::OUT_W-1:0]     log2_expected [$];
	int                                   error_count = 0;
	int                                   sent_count = 0;
	int                                   checked_count = 0;
	int                                   tx_burst_left = 0;
	bit                                   hold_req = 1'b0;

	fast_log2_approx_core #(
		.FRAC_BITS(FRAC)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.float_bits(float_bits),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.log2_value(log2_value)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

	function automatic logic signed [fla_pkg::OUT_W-1:0] log2_fixed_of(input logic [31:0] bits);
		logic [63:0] coarse;
		logic [63:0] mant_q30;
		logic [63:0] slope_term;
		logic [63:0] divisor;
		logic [63:0] ratio_term;
		logic [63:0] biased;
		logic [63:0] rounded;
		longint      value;
		coarse     = {32'd0, bits} << 7;
		mant_q30   = {40'd0, 1'b1, bits[22:0]} << 6;
		slope_term = (SLOPE_Q30 * mant_q30 + (64'd1 << 29)) >> 30;
		divisor    = POLE_Q30 + mant_q30;
		ratio_term = ((NUMER_Q30 << 30) + (divisor >> 1)) / divisor;
		biased     = coarse + (64'd1 << 40) - (LOG_OFFSET_Q30 + slope_term + ratio_term);
		rounded    = (biased + (64'd1 << (RND_SHIFT - 1))) >> RND_SHIFT;
		value      = longint'(rounded) - longint'(64'd1 << (40 - RND_SHIFT));
		if (value > LOG2_MAX) begin
			value = LOG2_MAX;
		end
		if (value < LOG2_MIN) begin
			value = LOG2_MIN;
		end
		return value[fla_pkg::OUT_W-1:0];
	endfunction

	function automatic logic [31:0] random_float();
		logic [31:0] bits;
		logic [7:0]  expo;
		logic [22:0] mant;
		bits = $urandom();
		expo = 8'($urandom_range(1, 254));
		mant = 23'($urandom());
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				return bits;
			end
			5, 6, 7: begin
				return {1'b0, expo, mant};
			end
			8: begin
				case ($urandom_range(0, 2))
					0: mant = '0;
					1: mant = '1;
					default: mant = 23'd1 << $urandom_range(0, 22);
				endcase
				return {bits[31], bits[30:23], mant};
			end
			default: begin
				return {bits[31], bits[0] ? 8'hFF : 8'h00, mant};
			end
		endcase
	endfunction

	task automatic send_float(input logic [31:0] bits);
		logic took;
		in_valid   <= 1'b1;
		float_bits <= bits;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		log2_expected.push_back(log2_fixed_of(bits));
		sent_count++;
	endtask

	task automatic pace_sender();
		if (tx_burst_left > 0) begin
			tx_burst_left--;
		end else begin
			in_valid <= 1'b0;
			if ($urandom_range(0, 9) == 0) begin
				repeat ($urandom_range(15, 40)) @(posedge clk);
			end else begin
				repeat ($urandom_range(1, 6)) @(posedge clk);
			end
			tx_burst_left = $urandom_range(0, 31);
		end
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do begin
			@(posedge clk);
		end while (log2_expected.size() != 0);
	endtask

	initial begin
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		float_bits = '0;
		out_ready  = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++) begin
			send_float(DIRECTED_FLOATS[i]);
			pace_sender();
		end
		drain_results();

		// fill the pipeline against a stalled receiver
		hold_req      = 1'b1;
		tx_burst_left = STALL_ITEMS;
		for (int i = 0; i < STALL_ITEMS; i++) begin
			send_float(random_float());
		end
		tx_burst_left = 0;
		pace_sender();

		for (int i = 0; i < RANDOM_ITEMS; i++) begin
			send_float(random_float());
			pace_sender();
		end
		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("Run: %0d float patterns sent (%0d directed), %0d log2 results checked,",
			sent_count, N_DIRECTED, checked_count);
		$display("  with bursty input, varied output stalls and one %0d-cycle output hold.",
			HOLD_CYCLES);
		if (error_count == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		int       seg_left;
		rx_mode_t rx_mode;
		seg_left = 0;
		rx_mode  = RX_OPEN;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
				out_ready <= 1'b1;
			end else begin
				if (seg_left == 0) begin
					rx_mode  = rx_mode_t'($urandom_range(0, 3));
					seg_left = $urandom_range(10, 150);
				end
				seg_left--;
				case (rx_mode)
					RX_OPEN:     out_ready <= 1'b1;
					RX_COIN:     out_ready <= 1'($urandom_range(0, 1));
					RX_SPARSE:   out_ready <= ($urandom_range(0, 3) == 0);
					RX_PERIODIC: out_ready <= (seg_left % 3 != 0);
					default:     out_ready <= 1'b1;
				endcase
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (log2_expected.size() == 0) begin
				$error("log2_value: expected none, got %0d", log2_value);
				error_count++;
			end else begin
				if (log2_value !== log2_expected[0]) begin
					$error("log2_value: expected %0d, got %0d", log2_expected[0], log2_value);
					error_count++;
				end
				void'(log2_expected.pop_front());
				checked_count++;
			end
		end
	end

endmodule

// File: files.f
rtl/fla_pkg.sv
rtl/fla_front.sv
rtl/fla_div.sv
rtl/fla_out.sv
rtl/fast_log2_approx_core.sv
sim/testbench.sv
